[src/ray_sphere_intersect_core_macros.svh]
// Assertion macros shared by the ray/sphere intersection core.
`ifndef RAY_SPHERE_INTERSECT_CORE_MACROS_SVH
`define RAY_SPHERE_INTERSECT_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define RSI_ASSERT_IMPLY(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("ray_sphere_intersect_core: assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define RSI_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("ray_sphere_intersect_core: assertion failed");

`endif

[src/rsi_pkg.sv]
// Shared widths, constants and stage types of the ray/sphere intersection core.
package rsi_pkg;

   localparam int COORD_W = 32;
   localparam int FRAC_W  = 16;

   localparam int OC_W   = COORD_W + 1;
   localparam int A_W    = 2 * COORD_W;
   localparam int H_W    = 2 * COORD_W + 2;
   localparam int C_W    = 2 * COORD_W + 3;
   localparam int MAG_W  = H_W;
   localparam int HALF_W = MAG_W / 2;
   localparam int Q_W    = 2 * MAG_W;
   localparam int X_W    = Q_W - 1;
   localparam int T_W    = X_W + 2;
   localparam int S_W    = X_W / 2 + 1;
   localparam int N_W    = S_W + 2;
   localparam int M_W    = N_W + FRAC_W;
   localparam int QT_W   = COORD_W + 1;
   localparam int R_W    = A_W + QT_W;

   localparam int FRONT_STAGES = 3;
   localparam int QUAD_STAGES  = 4;
   localparam int DIV_EXTRA    = 4;
   localparam int LATENCY      = FRONT_STAGES + QUAD_STAGES + S_W + DIV_EXTRA + QT_W;

   localparam logic [COORD_W-1:0] MISS_DIST = {{(COORD_W-FRAC_W){1'b1}}, {FRAC_W{1'b0}}};
   localparam logic [COORD_W-1:0] DIST_MAX  = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic [COORD_W-1:0] DIST_MIN  = {1'b1, {(COORD_W-1){1'b0}}};
   localparam logic [COORD_W-1:0] CENTER_Z_RESET = {{(COORD_W-FRAC_W){1'b1}}, {FRAC_W{1'b0}}};
   localparam logic [COORD_W-1:0] RADIUS_RESET   = COORD_W'(1) << (FRAC_W - 1);

   typedef enum logic [1:0] {
      REG_CENTER_X = 2'd0,
      REG_CENTER_Y = 2'd1,
      REG_CENTER_Z = 2'd2,
      REG_RADIUS   = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] center_x;
      logic signed [COORD_W-1:0] center_y;
      logic signed [COORD_W-1:0] center_z;
      logic signed [COORD_W-1:0] radius;
   } sphere_cfg_type;

   typedef struct packed {
      logic                  valid;
      logic [A_W-1:0]        a;
      logic signed [H_W-1:0] h;
      logic signed [C_W-1:0] c;
   } terms_type;

   typedef struct packed {
      logic                  valid;
      logic                  miss;
      logic signed [Q_W-1:0] q;
      logic [A_W-1:0]        a;
      logic signed [H_W-1:0] h;
   } disc_type;

   typedef struct packed {
      logic                  valid;
      logic                  miss;
      logic [S_W-1:0]        root;
      logic [A_W-1:0]        a;
      logic signed [H_W-1:0] h;
   } root_type;

endpackage

[src/rsi_front.sv]
// Front pipeline: offset from the center, first products and the terms a, h and c.
module rsi_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   input  logic signed [rsi_pkg::COORD_W-1:0] origin_x,
   input  logic signed [rsi_pkg::COORD_W-1:0] origin_y,
   input  logic signed [rsi_pkg::COORD_W-1:0] origin_z,
   input  logic signed [rsi_pkg::COORD_W-1:0] dir_x,
   input  logic signed [rsi_pkg::COORD_W-1:0] dir_y,
   input  logic signed [rsi_pkg::COORD_W-1:0] dir_z,
   input  rsi_pkg::sphere_cfg_type            cfg,
   output rsi_pkg::terms_type                 terms
);

   logic signed [rsi_pkg::COORD_W-1:0] origin [3];
   logic signed [rsi_pkg::COORD_W-1:0] dir [3];
   logic signed [rsi_pkg::COORD_W-1:0] center [3];

   logic v1_ff, v2_ff, v3_ff;
   logic signed [rsi_pkg::OC_W-1:0]                  oc_ff [3];
   logic signed [rsi_pkg::COORD_W-1:0]               d_ff [3];
   logic signed [2*rsi_pkg::COORD_W-1:0]             dd_ff [3];
   logic signed [rsi_pkg::OC_W+rsi_pkg::COORD_W-1:0] od_ff [3];
   logic signed [2*rsi_pkg::OC_W-1:0]                oo_ff [3];
   logic signed [2*rsi_pkg::COORD_W-1:0]             rr_ff;
   logic [rsi_pkg::A_W-1:0]                          a_ff;
   logic signed [rsi_pkg::H_W-1:0]                   h_ff;
   logic signed [rsi_pkg::C_W-1:0]                   c_ff;

   always_comb begin
      origin[0] = origin_x;
      origin[1] = origin_y;
      origin[2] = origin_z;
      dir[0]    = dir_x;
      dir[1]    = dir_y;
      dir[2]    = dir_z;
      center[0] = cfg.center_x;
      center[1] = cfg.center_y;
      center[2] = cfg.center_z;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         oc_ff[i] <= {origin[i][rsi_pkg::COORD_W-1], origin[i]}
                   - {center[i][rsi_pkg::COORD_W-1], center[i]};
         d_ff[i]  <= dir[i];
         dd_ff[i] <= d_ff[i] * d_ff[i];
         od_ff[i] <= oc_ff[i] * d_ff[i];
         oo_ff[i] <= oc_ff[i] * oc_ff[i];
      end
      rr_ff <= cfg.radius * cfg.radius;
      a_ff  <= rsi_pkg::A_W'(unsigned'(dd_ff[0])) + rsi_pkg::A_W'(unsigned'(dd_ff[1]))
             + rsi_pkg::A_W'(unsigned'(dd_ff[2]));
      h_ff  <= rsi_pkg::H_W'(od_ff[0]) + rsi_pkg::H_W'(od_ff[1]) + rsi_pkg::H_W'(od_ff[2]);
      c_ff  <= rsi_pkg::C_W'(oo_ff[0]) + rsi_pkg::C_W'(oo_ff[1]) + rsi_pkg::C_W'(oo_ff[2])
             - rsi_pkg::C_W'(rr_ff);
   end

   assign terms.valid = v3_ff;
   assign terms.a     = a_ff;
   assign terms.h     = h_ff;
   assign terms.c     = c_ff;

endmodule

[src/rsi_quad.sv]
// Discriminant pipeline: wide products h*h and a*c built from products of 33-bit halves.
module rsi_quad (
   input  logic               clock,
   input  logic               reset,
   input  rsi_pkg::terms_type terms,
   output rsi_pkg::disc_type  disc
);

   logic v4_ff, v5_ff, v6_ff, v7_ff;
   logic [rsi_pkg::MAG_W-1:0] hmag_ff, cmag_ff;
   logic [rsi_pkg::A_W-1:0]   a4_ff, a5_ff, a6_ff, a7_ff;
   logic signed [rsi_pkg::H_W-1:0] h4_ff, h5_ff, h6_ff, h7_ff;
   logic cneg4_ff, cneg5_ff, cneg6_ff;
   logic azero4_ff, azero5_ff, azero6_ff, azero7_ff;
   logic [2*rsi_pkg::HALF_W-1:0] hh_ll_ff, hh_lh_ff, hh_hh_ff;
   logic [2*rsi_pkg::HALF_W-1:0] ac_ll_ff, ac_lh_ff, ac_hl_ff, ac_hh_ff;
   logic [rsi_pkg::Q_W-1:0]      hh_ff, ac_ff;
   logic signed [rsi_pkg::Q_W-1:0] q_ff;
   logic [rsi_pkg::MAG_W-1:0]    a_ext;

   assign a_ext = rsi_pkg::MAG_W'(a4_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else begin
         v4_ff <= terms.valid;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      hmag_ff   <= rsi_pkg::MAG_W'(terms.h[rsi_pkg::H_W-1] ? -terms.h : terms.h);
      cmag_ff   <= rsi_pkg::MAG_W'(terms.c[rsi_pkg::C_W-1] ? -terms.c : terms.c);
      cneg4_ff  <= terms.c[rsi_pkg::C_W-1];
      azero4_ff <= (terms.a == '0);
      a4_ff     <= terms.a;
      h4_ff     <= terms.h;

      hh_ll_ff  <= hmag_ff[rsi_pkg::HALF_W-1:0] * hmag_ff[rsi_pkg::HALF_W-1:0];
      hh_lh_ff  <= hmag_ff[rsi_pkg::HALF_W-1:0] * hmag_ff[rsi_pkg::MAG_W-1:rsi_pkg::HALF_W];
      hh_hh_ff  <= hmag_ff[rsi_pkg::MAG_W-1:rsi_pkg::HALF_W]
                 * hmag_ff[rsi_pkg::MAG_W-1:rsi_pkg::HALF_W];
      ac_ll_ff  <= a_ext[rsi_pkg::HALF_W-1:0] * cmag_ff[rsi_pkg::HALF_W-1:0];
      ac_lh_ff  <= a_ext[rsi_pkg::HALF_W-1:0] * cmag_ff[rsi_pkg::MAG_W-1:rsi_pkg::HALF_W];
      ac_hl_ff  <= a_ext[rsi_pkg::MAG_W-1:rsi_pkg::HALF_W] * cmag_ff[rsi_pkg::HALF_W-1:0];
      ac_hh_ff  <= a_ext[rsi_pkg::MAG_W-1:rsi_pkg::HALF_W]
                 * cmag_ff[rsi_pkg::MAG_W-1:rsi_pkg::HALF_W];
      cneg5_ff  <= cneg4_ff;
      azero5_ff <= azero4_ff;
      a5_ff     <= a4_ff;
      h5_ff     <= h4_ff;

      // The cross term of h*h appears twice, hence the extra shift.
      hh_ff     <= (rsi_pkg::Q_W'(hh_hh_ff) << rsi_pkg::MAG_W)
                 + (rsi_pkg::Q_W'(hh_lh_ff) << (rsi_pkg::HALF_W + 1))
                 + rsi_pkg::Q_W'(hh_ll_ff);
      ac_ff     <= (rsi_pkg::Q_W'(ac_hh_ff) << rsi_pkg::MAG_W)
                 + (rsi_pkg::Q_W'(ac_lh_ff) << rsi_pkg::HALF_W)
                 + (rsi_pkg::Q_W'(ac_hl_ff) << rsi_pkg::HALF_W)
                 + rsi_pkg::Q_W'(ac_ll_ff);
      cneg6_ff  <= cneg5_ff;
      azero6_ff <= azero5_ff;
      a6_ff     <= a5_ff;
      h6_ff     <= h5_ff;

      q_ff      <= cneg6_ff ? (hh_ff + ac_ff) : (hh_ff - ac_ff);
      azero7_ff <= azero6_ff;
      a7_ff     <= a6_ff;
      h7_ff     <= h6_ff;
   end

   assign disc.valid = v7_ff;
   assign disc.miss  = azero7_ff;
   assign disc.q     = q_ff;
   assign disc.a     = a7_ff;
   assign disc.h     = h7_ff;

endmodule

[src/rsi_sqrt.sv]
// Square root pipeline: one root bit per stage, restoring, no multiplier.
module rsi_sqrt (
   input  logic              clock,
   input  logic              reset,
   input  rsi_pkg::disc_type disc,
   output rsi_pkg::root_type root
);

   logic [rsi_pkg::X_W-1:0]        x_ff [rsi_pkg::S_W];
   logic [rsi_pkg::S_W-1:0]        r_ff [rsi_pkg::S_W];
   logic [rsi_pkg::A_W-1:0]        a_ff [rsi_pkg::S_W];
   logic signed [rsi_pkg::H_W-1:0] h_ff [rsi_pkg::S_W];
   logic                           miss_ff [rsi_pkg::S_W];
   logic                           v_ff [rsi_pkg::S_W];

   for (genvar k = 0; k < rsi_pkg::S_W; k++) begin : g_stage
      localparam int BIT = rsi_pkg::S_W - 1 - k;
      logic [rsi_pkg::X_W-1:0]        x_src;
      logic [rsi_pkg::S_W-1:0]        r_src;
      logic [rsi_pkg::A_W-1:0]        a_src;
      logic signed [rsi_pkg::H_W-1:0] h_src;
      logic                           miss_src, v_src;
      logic [rsi_pkg::T_W-1:0]        trial;
      logic                           take;

      if (k == 0) begin : g_head
         // A negative discriminant is a miss; its radicand bits are then don't-care.
         assign x_src    = disc.q[rsi_pkg::X_W-1:0];
         assign r_src    = '0;
         assign a_src    = disc.a;
         assign h_src    = disc.h;
         assign miss_src = disc.miss | disc.q[rsi_pkg::Q_W-1];
         assign v_src    = disc.valid;
      end else begin : g_body
         assign x_src    = x_ff[k-1];
         assign r_src    = r_ff[k-1];
         assign a_src    = a_ff[k-1];
         assign h_src    = h_ff[k-1];
         assign miss_src = miss_ff[k-1];
         assign v_src    = v_ff[k-1];
      end

      // (r + 2^i)^2 - r^2 = r*2^(i+1) + 2^(2i)
      assign trial = (rsi_pkg::T_W'(r_src) << (BIT + 1)) + (rsi_pkg::T_W'(1) << (2 * BIT));
      assign take  = (rsi_pkg::T_W'(x_src) >= trial);

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else begin
            v_ff[k] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         x_ff[k]    <= take ? (x_src - trial[rsi_pkg::X_W-1:0]) : x_src;
         r_ff[k]    <= take ? (r_src | (rsi_pkg::S_W'(1) << BIT)) : r_src;
         a_ff[k]    <= a_src;
         h_ff[k]    <= h_src;
         miss_ff[k] <= miss_src;
      end
   end

   assign root.valid = v_ff[rsi_pkg::S_W-1];
   assign root.miss  = miss_ff[rsi_pkg::S_W-1];
   assign root.root  = r_ff[rsi_pkg::S_W-1];
   assign root.a     = a_ff[rsi_pkg::S_W-1];
   assign root.h     = h_ff[rsi_pkg::S_W-1];

endmodule

[src/rsi_div.sv]
// Root numerator, restoring divider pipeline and floor/saturation of the hit distance.
module rsi_div (
   input  logic                        clock,
   input  logic                        reset,
   input  rsi_pkg::root_type           root,
   output logic                        out_valid,
   output logic [rsi_pkg::COORD_W-1:0] out_distance,
   output logic                        out_hit
);

   logic v1_ff, v2_ff, v3_ff, vo_ff;
   logic signed [rsi_pkg::N_W-1:0] n0_ff;
   logic [rsi_pkg::M_W-1:0]        m2_ff;
   logic [rsi_pkg::R_W-1:0]        rem3_ff;
   logic [rsi_pkg::A_W-1:0]        a1_ff, a2_ff, a3_ff;
   logic miss1_ff, miss2_ff, miss3_ff;
   logic neg2_ff, neg3_ff, ovf3_ff;

   logic [rsi_pkg::R_W-1:0]  rem_ff [rsi_pkg::QT_W];
   logic [rsi_pkg::QT_W-1:0] quo_ff [rsi_pkg::QT_W];
   logic [rsi_pkg::A_W-1:0]  a_ff [rsi_pkg::QT_W];
   logic                     neg_ff [rsi_pkg::QT_W];
   logic                     ovf_ff [rsi_pkg::QT_W];
   logic                     miss_ff [rsi_pkg::QT_W];
   logic                     v_ff [rsi_pkg::QT_W];

   logic [rsi_pkg::COORD_W-1:0] dist_ff, dist_in;
   logic                        hit_ff;
   logic [rsi_pkg::QT_W-1:0]    quo_last;
   logic                        inexact;
   logic [rsi_pkg::QT_W:0]      ceil_q;
   logic                        pos_sat, neg_sat;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         v1_ff <= root.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         vo_ff <= v_ff[rsi_pkg::QT_W-1];
      end
   end

   always_ff @(posedge clock) begin
      n0_ff    <= -rsi_pkg::N_W'(root.h) - rsi_pkg::N_W'(root.root);
      a1_ff    <= root.a;
      miss1_ff <= root.miss;

      neg2_ff  <= n0_ff[rsi_pkg::N_W-1];
      m2_ff    <= rsi_pkg::M_W'(n0_ff[rsi_pkg::N_W-1] ? -n0_ff : n0_ff) << rsi_pkg::FRAC_W;
      a2_ff    <= a1_ff;
      miss2_ff <= miss1_ff;

      // A quotient of 2^33 or more saturates whatever its low bits are.
      ovf3_ff  <= rsi_pkg::R_W'(m2_ff) >= (rsi_pkg::R_W'(a2_ff) << rsi_pkg::QT_W);
      rem3_ff  <= rsi_pkg::R_W'(m2_ff);
      neg3_ff  <= neg2_ff;
      a3_ff    <= a2_ff;
      miss3_ff <= miss2_ff;
   end

   for (genvar k = 0; k < rsi_pkg::QT_W; k++) begin : g_stage
      localparam int BIT = rsi_pkg::QT_W - 1 - k;
      logic [rsi_pkg::R_W-1:0]  rem_src, sub;
      logic [rsi_pkg::QT_W-1:0] quo_src;
      logic [rsi_pkg::A_W-1:0]  a_src;
      logic                     neg_src, ovf_src, miss_src, v_src, take;

      if (k == 0) begin : g_head
         assign rem_src  = rem3_ff;
         assign quo_src  = '0;
         assign a_src    = a3_ff;
         assign neg_src  = neg3_ff;
         assign ovf_src  = ovf3_ff;
         assign miss_src = miss3_ff;
         assign v_src    = v3_ff;
      end else begin : g_body
         assign rem_src  = rem_ff[k-1];
         assign quo_src  = quo_ff[k-1];
         assign a_src    = a_ff[k-1];
         assign neg_src  = neg_ff[k-1];
         assign ovf_src  = ovf_ff[k-1];
         assign miss_src = miss_ff[k-1];
         assign v_src    = v_ff[k-1];
      end

      assign sub  = rsi_pkg::R_W'(a_src) << BIT;
      assign take = (rem_src >= sub);

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else begin
            v_ff[k] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[k]  <= take ? (rem_src - sub) : rem_src;
         quo_ff[k]  <= take ? (quo_src | (rsi_pkg::QT_W'(1) << BIT)) : quo_src;
         a_ff[k]    <= a_src;
         neg_ff[k]  <= neg_src;
         ovf_ff[k]  <= ovf_src;
         miss_ff[k] <= miss_src;
      end
   end

   // A negative numerator rounds toward minus infinity: negate the ceiling of |n|/a.
   assign quo_last = quo_ff[rsi_pkg::QT_W-1];
   assign inexact  = (rem_ff[rsi_pkg::QT_W-1] != '0);
   assign ceil_q   = {1'b0, quo_last} + (rsi_pkg::QT_W+1)'(inexact);
   assign pos_sat  = (quo_last[rsi_pkg::QT_W-1:rsi_pkg::COORD_W-1] != '0);
   assign neg_sat  = (ceil_q > ((rsi_pkg::QT_W+1)'(1) << (rsi_pkg::COORD_W - 1)));

   always_comb begin
      if (miss_ff[rsi_pkg::QT_W-1]) begin
         dist_in = rsi_pkg::MISS_DIST;
      end else if (ovf_ff[rsi_pkg::QT_W-1]) begin
         dist_in = neg_ff[rsi_pkg::QT_W-1] ? rsi_pkg::DIST_MIN : rsi_pkg::DIST_MAX;
      end else if (neg_ff[rsi_pkg::QT_W-1]) begin
         dist_in = neg_sat ? rsi_pkg::DIST_MIN : -ceil_q[rsi_pkg::COORD_W-1:0];
      end else begin
         dist_in = pos_sat ? rsi_pkg::DIST_MAX : quo_last[rsi_pkg::COORD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      dist_ff <= dist_in;
      hit_ff  <= ~miss_ff[rsi_pkg::QT_W-1];
   end

   assign out_valid    = vo_ff;
   assign out_distance = dist_ff;
   assign out_hit      = hit_ff;

endmodule

[src/ray_sphere_intersect_core.sv]
// Each start transaction that is taken yields one result strobe, in the order taken.
// Most of the pipeline is the 66-stage square root and the 33-stage divider pipeline.
// Throughput: one ray per cycle while busy is low, with any number of rays in flight.
// Reset (synchronous) clears all valid bits and restores the sphere registers;
// busy is high during reset and falls in the cycle after reset is released, otherwise low.
// The result strobe cannot be held off by the receiver.
`include "ray_sphere_intersect_core_macros.svh"

module ray_sphere_intersect_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic signed [rsi_pkg::COORD_W-1:0] req_origin_x,
   input  logic signed [rsi_pkg::COORD_W-1:0] req_origin_y,
   input  logic signed [rsi_pkg::COORD_W-1:0] req_origin_z,
   input  logic signed [rsi_pkg::COORD_W-1:0] req_dir_x,
   input  logic signed [rsi_pkg::COORD_W-1:0] req_dir_y,
   input  logic signed [rsi_pkg::COORD_W-1:0] req_dir_z,
   input  logic                               csr_wr_en,
   input  logic [1:0]                         csr_index,
   input  logic [rsi_pkg::COORD_W-1:0]        csr_wdata,
   output logic                               rsp_valid,
   output logic signed [rsi_pkg::COORD_W-1:0] rsp_hit_distance,
   output logic                               rsp_is_hit
);

   rsi_pkg::sphere_cfg_type cfg_ff;
   logic                    busy_ff;
   logic                    accept;
   rsi_pkg::terms_type      terms;
   rsi_pkg::disc_type       disc;
   rsi_pkg::root_type       root;
   logic [rsi_pkg::COORD_W-1:0] distance;

   assign accept = start & ~busy_ff;
   assign busy   = busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff         <= 1'b1;
         cfg_ff.center_x <= '0;
         cfg_ff.center_y <= '0;
         cfg_ff.center_z <= rsi_pkg::CENTER_Z_RESET;
         cfg_ff.radius   <= rsi_pkg::RADIUS_RESET;
      end else begin
         busy_ff <= 1'b0;
         if (csr_wr_en) begin
            case (rsi_pkg::reg_index_type'(csr_index))
               rsi_pkg::REG_CENTER_X: cfg_ff.center_x <= csr_wdata;
               rsi_pkg::REG_CENTER_Y: cfg_ff.center_y <= csr_wdata;
               rsi_pkg::REG_CENTER_Z: cfg_ff.center_z <= csr_wdata;
               rsi_pkg::REG_RADIUS:   cfg_ff.radius   <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   rsi_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .origin_x (req_origin_x),
      .origin_y (req_origin_y),
      .origin_z (req_origin_z),
      .dir_x    (req_dir_x),
      .dir_y    (req_dir_y),
      .dir_z    (req_dir_z),
      .cfg      (cfg_ff),
      .terms    (terms)
   );

   rsi_quad u_quad (
      .clock (clock),
      .reset (reset),
      .terms (terms),
      .disc  (disc)
   );

   rsi_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .disc  (disc),
      .root  (root)
   );

   rsi_div u_div (
      .clock        (clock),
      .reset        (reset),
      .root         (root),
      .out_valid    (rsp_valid),
      .out_distance (distance),
      .out_hit      (rsp_is_hit)
   );

   assign rsp_hit_distance = distance;

   // Every result transaction traces back to a start transaction a fixed latency earlier.
   `RSI_ASSERT_IMPLY(a_latency, clock, reset, rsp_valid, $past(accept, rsi_pkg::LATENCY))
   // A miss always reports a distance of minus one.
   `RSI_ASSERT_IMPLY(a_miss_value, clock, reset, rsp_valid && !rsp_is_hit,
      rsp_hit_distance == rsi_pkg::MISS_DIST)
   // Busy only covers reset; the pipeline never refuses a ray otherwise.
   `RSI_ASSERT_NEXT(a_never_busy, clock, 1'b0, !reset, !busy)

endmodule

[sim/tb_top.sv]
// Self-checking testbench for the ray/sphere intersection core.
module tb_top;

   localparam int WATCHDOG_LIMIT = 5000;

   typedef logic signed [191:0] wide_type;
   typedef logic signed [rsi_pkg::COORD_W-1:0] coord_type;

   typedef struct {
      coord_type ox, oy, oz, dx, dy, dz;
   } ray_type;

   typedef struct {
      coord_type hit_distance;
      logic      hit;
   } hit_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   coord_type req_origin_x = '0, req_origin_y = '0, req_origin_z = '0;
   coord_type req_dir_x = '0, req_dir_y = '0, req_dir_z = '0;
   logic csr_wr_en = 1'b0;
   logic [1:0] csr_index = '0;
   logic [rsi_pkg::COORD_W-1:0] csr_wdata = '0;
   logic rsp_valid;
   coord_type rsp_hit_distance;
   logic rsp_is_hit;

   ray_type ray_q[$];
   hit_type expected_hits[$];
   coord_type sph_cx, sph_cy, sph_cz, sph_r;
   int error_count = 0;
   int stall_pct = 38;
   int quiet_cycles = 0;

   ray_sphere_intersect_core u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_origin_x(req_origin_x), .req_origin_y(req_origin_y),
      .req_origin_z(req_origin_z), .req_dir_x(req_dir_x),
      .req_dir_y(req_dir_y), .req_dir_z(req_dir_z),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .rsp_valid(rsp_valid), .rsp_hit_distance(rsp_hit_distance),
      .rsp_is_hit(rsp_is_hit)
   );

   always #4 clock = ~clock;

   function automatic wide_type widen(coord_type v);
      return {{(192-rsi_pkg::COORD_W){v[rsi_pkg::COORD_W-1]}}, v};
   endfunction

   function automatic void add_ray(ray_type r);
      ray_q.insert(ray_q.size(), r);
   endfunction

   function automatic void add_expected(hit_type h);
      expected_hits.insert(expected_hits.size(), h);
   endfunction

   // Exact integer form of the nearest-root computation.
   function automatic hit_type intersect_sphere(ray_type r);
      wide_type o0, o1, o2, d0, d1, d2, rad, a, h, c, q, s, cand, num, t;
      hit_type res;
      o0 = widen(r.ox) - widen(sph_cx);
      o1 = widen(r.oy) - widen(sph_cy);
      o2 = widen(r.oz) - widen(sph_cz);
      d0 = widen(r.dx);
      d1 = widen(r.dy);
      d2 = widen(r.dz);
      rad = widen(sph_r);
      a = d0 * d0 + d1 * d1 + d2 * d2;
      h = o0 * d0 + o1 * d1 + o2 * d2;
      c = o0 * o0 + o1 * o1 + o2 * o2 - rad * rad;
      q = h * h - a * c;
      if (a == wide_type'(0) || q < wide_type'(0)) begin
         res.hit_distance = rsi_pkg::MISS_DIST;
         res.hit = 1'b0;
         return res;
      end
      s = '0;
      for (int i = 80; i >= 0; i--) begin
         cand = s | (wide_type'(1) <<< i);
         if (cand * cand <= q) s = cand;
      end
      num = (-h - s) <<< rsi_pkg::FRAC_W;
      t = num / a;
      // Division truncates toward zero; the result wants the floor.
      if (num < wide_type'(0) && t * a != num) t = t - wide_type'(1);
      if (t > widen(rsi_pkg::DIST_MAX)) t = widen(rsi_pkg::DIST_MAX);
      if (t < widen(rsi_pkg::DIST_MIN)) t = widen(rsi_pkg::DIST_MIN);
      res.hit_distance = t[rsi_pkg::COORD_W-1:0];
      res.hit = 1'b1;
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [rsi_pkg::COORD_W-1:0] got,
                                  logic [rsi_pkg::COORD_W-1:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
      error_count++;
   endtask

   // Driver: one ray transaction is taken when start is high and busy is low.
   always @(posedge clock) begin
      ray_type r;
      if (reset) begin
         start <= 1'b0;
      end else if (!start || !busy) begin
         if (start) begin
            r.ox = req_origin_x; r.oy = req_origin_y; r.oz = req_origin_z;
            r.dx = req_dir_x; r.dy = req_dir_y; r.dz = req_dir_z;
            add_expected(intersect_sphere(r));
         end
         if (ray_q.size() > 0 && $urandom_range(99) >= stall_pct) begin
            r = ray_q.pop_front();
            req_origin_x <= r.ox; req_origin_y <= r.oy; req_origin_z <= r.oz;
            req_dir_x <= r.dx; req_dir_y <= r.dy; req_dir_z <= r.dz;
            start <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: results cannot be held off, so each strobe is checked at once.
   always @(posedge clock) begin
      hit_type want;
      if (!reset && rsp_valid) begin
         if (expected_hits.size() == 0) begin
            report_mismatch("unexpected result", rsp_hit_distance, '0);
         end else begin
            want = expected_hits.pop_front();
            if (rsp_hit_distance !== want.hit_distance)
               report_mismatch("hit_distance", rsp_hit_distance, want.hit_distance);
            if (rsp_is_hit !== want.hit)
               report_mismatch("is_hit", rsi_pkg::COORD_W'(rsp_is_hit),
                               rsi_pkg::COORD_W'(want.hit));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic write_reg(rsi_pkg::reg_index_type idx, coord_type val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         rsi_pkg::REG_CENTER_X: sph_cx = val;
         rsi_pkg::REG_CENTER_Y: sph_cy = val;
         rsi_pkg::REG_CENTER_Z: sph_cz = val;
         rsi_pkg::REG_RADIUS:   sph_r = val;
         default: ;
      endcase
   endtask

   task automatic set_sphere(coord_type cx, coord_type cy, coord_type cz, coord_type r);
      write_reg(rsi_pkg::REG_CENTER_X, cx);
      write_reg(rsi_pkg::REG_CENTER_Y, cy);
      write_reg(rsi_pkg::REG_CENTER_Z, cz);
      write_reg(rsi_pkg::REG_RADIUS, r);
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (ray_q.size() != 0 || start || expected_hits.size() != 0);
      repeat (rsi_pkg::LATENCY + 10) @(posedge clock);
   endtask

   function automatic coord_type near_value(coord_type base, int span);
      return base + coord_type'($urandom_range(2 * span) - span);
   endfunction

   function automatic ray_type make_ray(coord_type ox, coord_type oy, coord_type oz,
                                        coord_type dx, coord_type dy, coord_type dz);
      ray_type r;
      r.ox = ox; r.oy = oy; r.oz = oz; r.dx = dx; r.dy = dy; r.dz = dz;
      return r;
   endfunction

   // Mostly rays aimed near the sphere, the rest unrestricted bit patterns.
   task automatic queue_random_rays(int count, int span);
      coord_type ox, oy, oz;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(99) < 70) begin
            ox = near_value(sph_cx, span);
            oy = near_value(sph_cy, span);
            oz = near_value(sph_cz, span);
            add_ray(make_ray(ox, oy, oz,
               near_value(sph_cx - ox, 1 << 12), near_value(sph_cy - oy, 1 << 12),
               near_value(sph_cz - oz, 1 << 12)));
         end else begin
            add_ray(make_ray($urandom, $urandom, $urandom,
                             $urandom, $urandom, $urandom));
         end
      end
   endtask

   initial begin
      coord_type one, cmax, cmin;
      one = 32'sh0001_0000;
      cmax = rsi_pkg::DIST_MAX;
      cmin = rsi_pkg::DIST_MIN;
      sph_cx = '0;
      sph_cy = '0;
      sph_cz = rsi_pkg::CENTER_Z_RESET;
      sph_r = rsi_pkg::RADIUS_RESET;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed rays against the reset sphere.
      add_ray(make_ray(0, 0, 0, 0, 0, -one));
      add_ray(make_ray(0, 0, 0, 0, 0, 0));
      add_ray(make_ray(0, 0, 0, one, 0, 0));
      add_ray(make_ray(0, 0, -one, 0, 0, -one));
      add_ray(make_ray(0, 0, -2 * one, 0, 0, -one));
      add_ray(make_ray(0, 0, cmax, 0, 0, -1));
      add_ray(make_ray(0, 0, cmin, 0, 0, 1));
      add_ray(make_ray(0, 0, cmin, 0, 0, -1));
      add_ray(make_ray(cmax, cmax, cmax, cmax, cmax, cmax));
      add_ray(make_ray(cmin, cmin, cmin, cmin, cmin, cmin));
      add_ray(make_ray(cmax, cmin, cmax, cmin, cmax, cmin));
      add_ray(make_ray(0, 0, 0, cmin, cmin, cmin));
      add_ray(make_ray(0, one / 2, 0, 0, 0, -one));
      add_ray(make_ray(0, one / 2 + 1, 0, 0, 0, -one));
      add_ray(make_ray(0, 0, 0, 0, 0, -1));
      add_ray(make_ray(0, 0, 0, 3, -7, -one));
      add_ray(make_ray(-1, -1, -1, -1, -1, -1));
      add_ray(make_ray(0, 0, one, 0, 0, cmin));
      queue_random_rays(100, 1 << 18);
      wait_drained();

      set_sphere($urandom, $urandom, $urandom, $urandom_range(1 << 20));
      queue_random_rays(120, 1 << 20);
      wait_drained();

      // A stretch with no stalls at all.
      set_sphere(cmax, cmax, cmax, cmin);
      stall_pct = 0;
      queue_random_rays(100, 1 << 22);
      wait_drained();
      stall_pct = 38;

      set_sphere(cmin, cmin, cmin, cmax);
      queue_random_rays(100, 1 << 24);
      wait_drained();

      set_sphere(0, 0, 0, 0);
      queue_random_rays(80, 1 << 16);
      wait_drained();

      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule

[filelist.f]
+incdir+src
src/rsi_pkg.sv
src/rsi_front.sv
src/rsi_quad.sv
src/rsi_sqrt.sv
src/rsi_div.sv
src/ray_sphere_intersect_core.sv
sim/tb_top.sv
